// ===== sv/sfr_pkg.sv =====
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int NUM_RELAYS  = 5;
	localparam int HEADER_BYTES = 6;
	localparam int RELAY_FRAME_LEN = 5;
	localparam int VALUE_OFFSET = 4;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] RELAY_STATE_MARK = 8'h01;

	typedef enum logic [2:0] {
		REG_DATA_CODE = 3'd0,
		REG_TIME_CODE = 3'd1,
		REG_RELAY_A   = 3'd2,
		REG_RELAY_B   = 3'd3,
		REG_RELAY_C   = 3'd4,
		REG_RELAY_D   = 3'd5,
		REG_RELAY_E   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_STRAY    = 3'd1,
		ST_BAD_SYNC = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_BAD_SUM  = 3'd4
	} status_t;

	// Frame event handed from the parser to the decoder.
	typedef struct packed {
		status_t    status;
		logic [7:0] version;
		logic [7:0] command;
		logic [7:0] length;
		logic [7:0] first;
		logic [7:0] second;
		logic       value_nz;
	} evt_t;

	typedef struct packed {
		logic [7:0]                 data_code;
		logic [7:0]                 time_code;
		logic [NUM_RELAYS-1:0][7:0] relay_ids;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] version;
		logic [7:0] command;
		logic [7:0] length;
		logic       relay_event;
		logic [7:0] relay_id;
		logic       relay_on;
		logic       time_request;
	} res_t;

endpackage

// ===== sv/sfr_regs.sv =====
// Configuration register file behind the APB-style port.
module sfr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0] paddr,
	input  logic [sfr_pkg::DATA_W-1:0] pwdata,
	output logic [sfr_pkg::DATA_W-1:0] prdata,
	output sfr_pkg::cfg_t              cfg
);

	sfr_pkg::cfg_t     cfg_q;
	sfr_pkg::reg_idx_t idx;
	logic              wr_en;
	logic [7:0]        rd_val;

	assign idx   = sfr_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_code    <= 8'd7;
			cfg_q.time_code    <= 8'd28;
			cfg_q.relay_ids[0] <= 8'd1;
			cfg_q.relay_ids[1] <= 8'd2;
			cfg_q.relay_ids[2] <= 8'd3;
			cfg_q.relay_ids[3] <= 8'd4;
			cfg_q.relay_ids[4] <= 8'd5;
		end else if (wr_en) begin
			unique case (idx)
				sfr_pkg::REG_DATA_CODE: cfg_q.data_code    <= pwdata[7:0];
				sfr_pkg::REG_TIME_CODE: cfg_q.time_code    <= pwdata[7:0];
				sfr_pkg::REG_RELAY_A:   cfg_q.relay_ids[0] <= pwdata[7:0];
				sfr_pkg::REG_RELAY_B:   cfg_q.relay_ids[1] <= pwdata[7:0];
				sfr_pkg::REG_RELAY_C:   cfg_q.relay_ids[2] <= pwdata[7:0];
				sfr_pkg::REG_RELAY_D:   cfg_q.relay_ids[3] <= pwdata[7:0];
				sfr_pkg::REG_RELAY_E:   cfg_q.relay_ids[4] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sfr_pkg::REG_DATA_CODE: rd_val = cfg_q.data_code;
			sfr_pkg::REG_TIME_CODE: rd_val = cfg_q.time_code;
			sfr_pkg::REG_RELAY_A:   rd_val = cfg_q.relay_ids[0];
			sfr_pkg::REG_RELAY_B:   rd_val = cfg_q.relay_ids[1];
			sfr_pkg::REG_RELAY_C:   rd_val = cfg_q.relay_ids[2];
			sfr_pkg::REG_RELAY_D:   rd_val = cfg_q.relay_ids[3];
			sfr_pkg::REG_RELAY_E:   rd_val = cfg_q.relay_ids[4];
			default:                rd_val = 8'd0;
		endcase
	end

	assign prdata = {{(sfr_pkg::DATA_W-8){1'b0}}, rd_val};

endmodule

// ===== sv/sfr_front.sv =====
// Byte parser: tracks frame position and checksum and classifies frame events.
module sfr_front #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	output logic          evt_valid,
	output sfr_pkg::evt_t evt
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES);
	localparam logic [15:0]      LEN_LIMIT = 16'(MAX_FRAME_BYTES - 7);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] HDR       = POS_W'(sfr_pkg::HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_P1    = POS_W'(sfr_pkg::HEADER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_VAL   =
		POS_W'(sfr_pkg::HEADER_BYTES + sfr_pkg::VALUE_OFFSET);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_q, sum_d, sum_add;
	logic [7:0]       ver_q, ver_d, cmd_q, cmd_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       p0_q, p0_d, p1_q, p1_d;
	logic             vnz_q, vnz_d;
	logic [16:0]      end_pos;
	logic             at_end;

	assign sum_add = sum_q + in_byte;
	assign end_pos = {1'b0, len_q} + 17'(HDR);
	assign at_end  = (17'(pos_q) == end_pos);

	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q;
		ver_d     = ver_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		p0_d      = p0_q;
		p1_d      = p1_q;
		vnz_d     = vnz_q;
		evt_valid = 1'b0;
		evt       = '0;
		if (in_valid) begin
			if (pos_q == '0) begin
				if (in_byte != sfr_pkg::SYNC_FIRST) begin
					evt_valid  = 1'b1;
					evt.status = sfr_pkg::ST_STRAY;
				end else begin
					sum_d = in_byte;
					pos_d = POS_W'(1);
				end
			end else if (pos_q == POS_W'(1) && in_byte != sfr_pkg::SYNC_SECOND) begin
				evt_valid  = 1'b1;
				evt.status = sfr_pkg::ST_BAD_SYNC;
				pos_d      = '0;
				sum_d      = '0;
			end else if (pos_q < HDR) begin
				if (pos_q == POS_W'(2)) ver_d = in_byte;
				if (pos_q == POS_W'(3)) cmd_d = in_byte;
				if (pos_q == POS_W'(4)) len_d[15:8] = in_byte;
				if (pos_q == POS_W'(5)) len_d[7:0] = in_byte;
				sum_d = sum_add;
				pos_d = pos_q + 1'b1;
			end else if (pos_q == HDR && len_q >= LEN_LIMIT) begin
				evt_valid   = 1'b1;
				evt.status  = sfr_pkg::ST_BAD_LEN;
				evt.version = ver_q;
				evt.command = cmd_q;
				pos_d       = '0;
				sum_d       = '0;
			end else if (at_end) begin
				// The byte at the end position is the checksum itself.
				evt_valid    = 1'b1;
				evt.status   = (sum_q == in_byte) ? sfr_pkg::ST_OK : sfr_pkg::ST_BAD_SUM;
				evt.version  = ver_q;
				evt.command  = cmd_q;
				evt.length   = len_q[7:0];
				evt.first    = p0_q;
				evt.second   = p1_q;
				evt.value_nz = vnz_q;
				pos_d        = '0;
				sum_d        = '0;
			end else begin
				if (pos_q == HDR)     p0_d  = in_byte;
				if (pos_q == POS_P1)  p1_d  = in_byte;
				if (pos_q == POS_VAL) vnz_d = (in_byte != 8'd0);
				sum_d = sum_add;
				if (pos_q == POS_LAST) begin
					pos_d = '0;
					sum_d = '0;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			ver_q <= '0;
			cmd_q <= '0;
			len_q <= '0;
			p0_q  <= '0;
			p1_q  <= '0;
			vnz_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			sum_q <= sum_d;
			ver_q <= ver_d;
			cmd_q <= cmd_d;
			len_q <= len_d;
			p0_q  <= p0_d;
			p1_q  <= p1_d;
			vnz_q <= vnz_d;
		end
	end

	// Once inside the payload, the held length has passed the bound check.
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q > HDR) |-> (len_q < LEN_LIMIT))
		else $error("payload position reached with an unchecked length");

endmodule

// ===== sv/sfr_fifo.sv =====
// Short queue of frame events between the parser and the decoder.
module sfr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  sfr_pkg::evt_t wdata,
	input  logic          rd,
	output sfr_pkg::evt_t rdata,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sfr_pkg::evt_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (wr && !rd) count_q <= count_q + 1'b1;
			else if (!wr && rd) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("event queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("event queue read while empty");

endmodule

// ===== sv/sfr_back.sv =====
// Event decoder: relay report and time request decode into the result register.
module sfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sfr_pkg::cfg_t cfg,
	input  logic          evt_avail,
	input  sfr_pkg::evt_t evt,
	output logic          evt_take,
	input  logic          res_pop,
	output logic          res_valid,
	output sfr_pkg::res_t res
);

	sfr_pkg::res_t res_q, res_d;
	logic          valid_q;
	logic          good, id_hit, rel;

	always_comb begin
		id_hit = 1'b0;
		for (int k = 0; k < sfr_pkg::NUM_RELAYS; k++) begin
			if (evt.first == cfg.relay_ids[k]) id_hit = 1'b1;
		end
	end

	assign good = (evt.status == sfr_pkg::ST_OK);
	assign rel  = good && id_hit && (evt.command == cfg.data_code) &&
		(evt.length == 8'(sfr_pkg::RELAY_FRAME_LEN)) &&
		(evt.second == sfr_pkg::RELAY_STATE_MARK);

	always_comb begin
		res_d.status       = evt.status;
		res_d.version      = evt.version;
		res_d.command      = evt.command;
		res_d.length       = evt.length;
		res_d.relay_event  = rel;
		res_d.relay_id     = rel ? evt.first : 8'd0;
		res_d.relay_on     = rel && evt.value_nz;
		res_d.time_request = good && (evt.command == cfg.time_code);
	end

	// A new result loads when the register is free or its beat leaves now.
	assign evt_take  = evt_avail && (!valid_q || res_pop);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (evt_take) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt_take) begin
			valid_q <= 1'b1;
		end else if (res_pop) begin
			valid_q <= 1'b0;
		end
	end

	a_event_fields_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.status != 3'(sfr_pkg::ST_OK)) |->
		(!res_q.relay_event && !res_q.time_request && !res_q.relay_on))
		else $error("event flags raised on a failed frame");

endmodule

// ===== sv/serial_frame_receiver_sum_check.sv =====
// Top level of the serial frame receiver with additive checksum.
//
// Bytes from a UART enter on rx_byte and are taken at an edge with push high
// and full low. Frames are 0x55, 0xAA, version, command, length (two bytes,
// high first), payload and an 8-bit wrapping sum of all earlier frame bytes.
// One result beat comes out for each finished frame, stray byte or framing
// error; header bytes and payload bytes give none. A result is on the output
// ports while empty is low and leaves at an edge with pop high.
// The parser takes one byte per cycle while full is low. A byte that ends a
// frame puts its event in the event queue at the edge that takes it; the
// event enters the output register once it heads the queue and the result
// register is free or its result leaves with pop. While pop stays low,
// results collect in the event queue (QUEUE_DEPTH entries) and the output
// register; full rises when the queue is full, so bytes are held off only
// then. The user must write configuration registers over the APB-style port
// only while no frame is in progress (not enforced here). Reset returns the
// parser to sync hunting, empties the queue and loads the register defaults.
module serial_frame_receiver_sum_check #(
	parameter int MAX_FRAME_BYTES = 256,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 rx_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic [2:0]                 frame_status,
	output logic [7:0]                 frame_version,
	output logic [7:0]                 frame_command,
	output logic [7:0]                 payload_length,
	output logic                       relay_event,
	output logic [7:0]                 relay_id,
	output logic                       relay_on,
	output logic                       time_request,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0] paddr,
	input  logic [sfr_pkg::DATA_W-1:0] pwdata,
	output logic [sfr_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	sfr_pkg::cfg_t cfg;
	sfr_pkg::evt_t evt_in, evt_out;
	sfr_pkg::res_t res;
	logic          accept, evt_valid, evt_take, q_empty, res_valid;

	assign pready = 1'b1;
	assign accept = push && !full;
	assign empty  = !res_valid;

	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sfr_front #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_byte   (rx_byte),
		.evt_valid (evt_valid),
		.evt       (evt_in)
	);

	sfr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (evt_valid),
		.wdata  (evt_in),
		.rd     (evt_take),
		.rdata  (evt_out),
		.full   (full),
		.empty  (q_empty)
	);

	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.evt_avail (!q_empty),
		.evt       (evt_out),
		.evt_take  (evt_take),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign frame_status   = res.status;
	assign frame_version  = res.version;
	assign frame_command  = res.command;
	assign payload_length = res.length;
	assign relay_event    = res.relay_event;
	assign relay_id       = res.relay_id;
	assign relay_on       = res.relay_on;
	assign time_request   = res.time_request;

endmodule
